// ===== rtl/prq_pkg.sv =====
// Package for the priority run queue scheduler: request codes, configuration indices,
// FSM states and default constants. No dependencies.
package prq_pkg;

    localparam int NUM_TASKS_DEF  = 64;
    localparam int NUM_LEVELS_DEF = 6;
    localparam logic [31:0] STARVE_RESET = 32'd1250;
    localparam logic [31:0] STEP_RESET   = 32'd102400;

    typedef enum logic [1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_PICK    = 2'd2,
        REQ_NOP     = 2'd3
    } req_t;

    typedef enum logic [0:0] {
        CFG_STARVE = 1'b0,
        CFG_STEP   = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD_TASK,
        ST_ENQ,
        ST_REM,
        ST_REM_PREV,
        ST_REM_NEXT,
        ST_SCAN,
        ST_SCAN_CHK,
        ST_DIV,
        ST_CHARGE,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/prq_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the runtime charge.
// Depends on prq_pkg.
module prq_divider
    import prq_pkg::*;
#(
    parameter int NUM_LEVELS = NUM_LEVELS_DEF,
    localparam int WW = $clog2(NUM_LEVELS + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [31:0]   dividend,
    input  logic [WW-1:0] divisor,
    output logic          done,
    output logic [31:0]   quotient
);

    logic [31:0]   q_reg, q_next;
    logic [WW:0]   r_reg, r_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic [WW-1:0] dv_reg;
    logic [WW:0]   trial;

    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        trial    = {r_reg[WW-1:0], q_reg[31]};
        done     = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            cnt_next = 6'd32;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            q_next = {q_reg[30:0], 1'b0};
            if (trial >= {1'b0, dv_reg})
            begin
                r_next    = trial - {1'b0, dv_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next = 1'b0;
                done     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            dv_reg <= divisor;
        end
    end

    assign quotient = q_next;

endmodule

// ===== rtl/prq_task_mem.sv =====
// Task table memory: one synchronous RAM row per task holding links, level,
// enqueue time and virtual runtime. One write and one read port. Uses prq_pkg.
module prq_task_mem
    import prq_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF,
    parameter int ROW_W     = 64
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(NUM_TASKS)-1:0] waddr,
    input  logic [ROW_W-1:0]             wdata,
    input  logic [$clog2(NUM_TASKS)-1:0] raddr,
    output logic [ROW_W-1:0]             rdata
);

    logic [ROW_W-1:0] mem [NUM_TASKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/priority_run_queue_scheduler_top.sv =====
// Every request, including a no-op, an empty pick and an ignored enqueue or remove, ends in a
// done strobe; a pick scans the levels and, unless a starved head is found, waits for the
// divider to charge the top head.
// One request at a time: the next is taken in the strobe cycle. The strobe cannot be stalled.
// After reset a clearing pass writes every task row while busy is high.
// Depends on prq_pkg, prq_task_mem and prq_divider.
module priority_run_queue_scheduler_top
    import prq_pkg::*;
#(
    parameter int NUM_TASKS  = NUM_TASKS_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [5:0]  task_id,
    input  logic [2:0]  priority_req,
    input  logic [63:0] now,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic        pick_valid,
    output logic [5:0]  picked_task,
    output logic        starved_pick,
    output logic [63:0] picked_runtime,
    output logic [6:0]  queued_count,
    output logic [5:0]  active_mask
);

    localparam int TW  = $clog2(NUM_TASKS);
    localparam int LKW = TW + 1;
    localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int WW  = $clog2(NUM_LEVELS + 1);
    localparam int CW  = $clog2(NUM_TASKS + 1);
    localparam int ROW_W = 2 * LKW + 1 + LW + 128;
    localparam logic [LKW-1:0] NIL = LKW'(NUM_TASKS);

    typedef struct packed {
        logic [LKW-1:0] nxt;
        logic [LKW-1:0] prv;
        logic           queued;
        logic [LW-1:0]  level;
        logic [63:0]    etime;
        logic [63:0]    vrt;
    } row_t;

    // Register file for configuration.
    logic [31:0] starve_reg;
    logic [31:0] step_reg;

    // Queue descriptors live in flops: only a handful of levels.
    logic [LKW-1:0]        head_reg [NUM_LEVELS];
    logic [LKW-1:0]        tail_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] mask_reg;
    logic [CW-1:0]         total_reg;
    logic [63:0]           floor_reg;

    state_t state_reg, state_next;

    // Latched request.
    logic [1:0]    rq_type_reg;
    logic [TW-1:0] rq_tid_reg;
    logic [LW-1:0] rq_lvl_reg;
    logic [63:0]   rq_now_reg;

    // Working registers.
    row_t          cur_reg;
    logic [TW-1:0] cur_id_reg;
    logic [TW:0]   clr_reg;
    logic [LW-1:0] scan_reg;
    logic          found_top_reg;
    logic [LW-1:0] top_reg;
    logic          starved_reg;
    logic          pick_reg;
    logic [LKW-1:0] rem_prv_reg, rem_nxt_reg;

    // Memory port.
    logic          mem_we;
    logic [TW-1:0] mem_waddr, mem_raddr;
    row_t          mem_wdata, mem_rdata;

    logic          div_start, div_done;
    logic [31:0]   div_q;
    logic [WW-1:0] div_w;

    prq_task_mem #(.NUM_TASKS(NUM_TASKS), .ROW_W(ROW_W)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    prq_divider #(.NUM_LEVELS(NUM_LEVELS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (step_reg),
        .divisor  (div_w),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_w = WW'(NUM_LEVELS) - WW'(top_reg);

    // Configuration is taken whenever offered; writes must only arrive while idle (not enforced here).
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            starve_reg <= STARVE_RESET;
            step_reg   <= STEP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_STARVE: starve_reg <= cfg_data;
                CFG_STEP:   step_reg   <= cfg_data;
            endcase
        end
    end

    logic [LW-1:0] enq_lvl;
    assign enq_lvl = (32'(priority_req) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
                                                       : LW'(priority_req);

    // Starvation test on the head row just read, and the charged runtime.
    logic [63:0]     wait_t;
    logic            starve_hit;
    logic [63:0]     charged;

    assign wait_t     = rq_now_reg - mem_rdata.etime;
    assign starve_hit = (rq_now_reg > mem_rdata.etime) && (wait_t > {32'd0, starve_reg});
    assign charged    = cur_reg.vrt + {32'd0, div_q};

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = cur_id_reg;
        mem_wdata  = cur_reg;
        mem_raddr  = rq_tid_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[TW-1:0];
                mem_wdata = '{nxt: NIL, prv: NIL, queued: 1'b0, level: '0,
                              etime: '0, vrt: '0};
                if (clr_reg == (TW+1)'(NUM_TASKS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                mem_raddr = TW'(task_id);
                if (start)
                begin
                    priority case (req_t'(req_type))
                        REQ_ENQUEUE, REQ_REMOVE: state_next = ST_RD_TASK;
                        REQ_PICK:   state_next = (mask_reg != '0) ? ST_SCAN : ST_DONE;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_RD_TASK:
            begin
                // Row of the requested task is on mem_rdata.
                if (rq_type_reg == REQ_ENQUEUE)
                begin
                    state_next = mem_rdata.queued ? ST_DONE : ST_ENQ;
                end
                else
                begin
                    state_next = mem_rdata.queued ? ST_REM : ST_DONE;
                end
            end
            ST_ENQ:
            begin
                mem_we = 1'b1;
                mem_wdata.nxt    = NIL;
                mem_wdata.prv    = tail_reg[rq_lvl_reg];
                mem_wdata.queued = 1'b1;
                mem_wdata.level  = rq_lvl_reg;
                mem_wdata.etime  = rq_now_reg;
                mem_wdata.vrt    = (cur_reg.vrt < floor_reg) ? floor_reg : cur_reg.vrt;
                mem_raddr = tail_reg[rq_lvl_reg][TW-1:0];
                state_next = (tail_reg[rq_lvl_reg] != NIL) ? ST_REM_PREV : ST_DONE;
            end
            ST_REM:
            begin
                // Unlink the removed task's row (charging its runtime on a non-starved pick); fetch its predecessor.
                mem_we = 1'b1;
                mem_wdata.nxt    = NIL;
                mem_wdata.prv    = NIL;
                mem_wdata.queued = 1'b0;
                if (pick_reg && !starved_reg)
                begin
                    mem_wdata.vrt = charged;
                end
                mem_raddr  = cur_reg.prv[TW-1:0];
                state_next = (cur_reg.prv != NIL) ? ST_REM_PREV :
                             (cur_reg.nxt != NIL) ? ST_REM_NEXT : ST_DONE;
            end
            ST_REM_PREV:
            begin
                // Patch predecessor's next link (enqueue: old tail -> new task).
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                mem_waddr = rem_prv_reg[TW-1:0];
                mem_wdata.nxt = (rq_type_reg == REQ_ENQUEUE) ? LKW'(cur_id_reg)
                                                             : rem_nxt_reg;
                mem_raddr  = rem_nxt_reg[TW-1:0];
                state_next = (rq_type_reg != REQ_ENQUEUE && rem_nxt_reg != NIL)
                             ? ST_REM_NEXT : ST_DONE;
            end
            ST_REM_NEXT:
            begin
                // Issue the read of the successor row, needed when coming directly from ST_REM.
                mem_raddr = rem_nxt_reg[TW-1:0];
                state_next = ST_CHARGE;
            end
            ST_CHARGE:
            begin
                mem_we    = 1'b1;
                mem_waddr = rem_nxt_reg[TW-1:0];
                mem_wdata = mem_rdata;
                mem_wdata.prv = rem_prv_reg;
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                // Skip empty levels; issue read of a head.
                mem_raddr = head_reg[scan_reg][TW-1:0];
                if (mask_reg[scan_reg] && head_reg[scan_reg] != NIL)
                begin
                    state_next = ST_SCAN_CHK;
                end
                else if (scan_reg == '0)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_SCAN_CHK:
            begin
                mem_raddr = head_reg[scan_reg][TW-1:0];
                if (starve_hit)
                begin
                    state_next = ST_REM;
                end
                else if (scan_reg == '0)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_DIV:
            begin
                // Reread top head and charge it; divider runs meanwhile.
                mem_raddr = head_reg[top_reg][TW-1:0];
                if (div_done)
                begin
                    state_next = ST_REM;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (state_reg == ST_SCAN && state_next == ST_DIV)
        begin
            div_start = 1'b1;
        end
        if (state_reg == ST_SCAN_CHK && state_next == ST_DIV)
        begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            mask_reg    <= '0;
            total_reg   <= '0;
            floor_reg   <= '0;
            done        <= 1'b0;
            pick_valid  <= 1'b0;
            picked_task <= '0;
            starved_pick   <= 1'b0;
            picked_runtime <= '0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg == ST_DONE);
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            unique case (state_reg)
                ST_ENQ:
                begin
                    if (tail_reg[rq_lvl_reg] == NIL)
                    begin
                        head_reg[rq_lvl_reg] <= LKW'(cur_id_reg);
                    end
                    tail_reg[rq_lvl_reg] <= LKW'(cur_id_reg);
                    mask_reg[rq_lvl_reg] <= 1'b1;
                    total_reg <= total_reg + 1'b1;
                end
                ST_REM:
                begin
                    if (cur_reg.prv == NIL)
                    begin
                        head_reg[cur_reg.level] <= cur_reg.nxt;
                        if (cur_reg.nxt == NIL)
                        begin
                            mask_reg[cur_reg.level] <= 1'b0;
                        end
                    end
                    if (cur_reg.nxt == NIL)
                    begin
                        tail_reg[cur_reg.level] <= cur_reg.prv;
                    end
                    if (total_reg != '0)
                    begin
                        total_reg <= total_reg - 1'b1;
                    end
                    if (pick_reg)
                    begin
                        pick_valid   <= 1'b1;
                        picked_task  <= 6'(cur_id_reg);
                        starved_pick <= starved_reg;
                        picked_runtime <= starved_reg ? cur_reg.vrt : charged;
                        if (!starved_reg && charged > floor_reg)
                        begin
                            floor_reg <= charged;
                        end
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        pick_valid     <= 1'b0;
                        picked_task    <= '0;
                        starved_pick   <= 1'b0;
                        picked_runtime <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers with no reset.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                rq_type_reg   <= req_type;
                rq_tid_reg    <= TW'(task_id);
                rq_lvl_reg    <= enq_lvl;
                rq_now_reg    <= now;
                cur_id_reg    <= TW'(task_id);
                scan_reg      <= LW'(NUM_LEVELS - 1);
                found_top_reg <= 1'b0;
                starved_reg   <= 1'b0;
                pick_reg      <= (req_type == REQ_PICK);
            end
            ST_RD_TASK:
            begin
                cur_reg     <= mem_rdata;
                rem_prv_reg <= mem_rdata.prv;
                rem_nxt_reg <= mem_rdata.nxt;
            end
            ST_ENQ:
            begin
                // Hold the old tail: its next link is patched in the following step.
                rem_prv_reg <= tail_reg[rq_lvl_reg];
            end
            ST_SCAN:
            begin
                if (mask_reg[scan_reg] && head_reg[scan_reg] != NIL)
                begin
                    if (!found_top_reg)
                    begin
                        top_reg       <= scan_reg;
                        found_top_reg <= 1'b1;
                    end
                end
                else if (scan_reg != '0)
                begin
                    scan_reg <= scan_reg - 1'b1;
                end
            end
            ST_SCAN_CHK:
            begin
                cur_reg     <= mem_rdata;
                cur_id_reg  <= head_reg[scan_reg][TW-1:0];
                rem_prv_reg <= mem_rdata.prv;
                rem_nxt_reg <= mem_rdata.nxt;
                if (starve_hit)
                begin
                    starved_reg <= 1'b1;
                end
                else if (scan_reg != '0)
                begin
                    scan_reg <= scan_reg - 1'b1;
                end
            end
            ST_DIV:
            begin
                cur_reg     <= mem_rdata;
                cur_id_reg  <= head_reg[top_reg][TW-1:0];
                rem_prv_reg <= mem_rdata.prv;
                rem_nxt_reg <= mem_rdata.nxt;
            end
            default:
            begin
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign queued_count = 7'(total_reg);
    assign active_mask  = 6'(mask_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(NUM_TASKS))
        else $error("queued count exceeds table size");
    a_pick_has_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REM && pick_reg) |=> (state_reg != ST_IDLE))
        else $error("pick result without completion");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe held");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> busy)
        else $error("idle during clear");
`endif

endmodule
